// ----- hw/rtl/b64u_pkg.sv -----
// shared types, constants and the url alphabet lookup for the base64url encoder
// used by the front, queue, back and top level modules; depends on nothing
package b64u_pkg;

    localparam logic [7:0] PAD_CHAR = 8'd61;
    localparam int unsigned JOB_SLOTS = 4;

    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } out_item_t;

    // characters produced by one byte, slot 0 first
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] chars;
        logic [1:0]                last_idx;
        logic                      fin;
    } job_t;

    function automatic logic [7:0] sym(input logic [5:0] six);
        logic [7:0] wide;
        wide = {2'b00, six};
        case (six) inside
            [6'd0:6'd25]:  sym = wide + 8'd65;
            [6'd26:6'd51]: sym = wide + 8'd71;
            [6'd52:6'd61]: sym = wide - 8'd4;
            6'd62:         sym = 8'd45;
            default:       sym = 8'd95;
        endcase
    endfunction

endpackage

// ----- hw/rtl/base64url_padded_encoder.sv -----
// top level of the streaming base64url encoder with '=' padding
// ties b64u_front, b64u_queue and b64u_back together; uses b64u_pkg
//
//   channel   handshake                payload
//   byte      byte_valid / byte_stall  byte_item  (byte_value, final_byte)
//   char      char_valid / char_stall  char_item  (char_code, final_char)
//
// one character leaves per cycle through the output register while char_stall is low; a byte
// yields one to four characters (two when it is the third byte of a group)
// the first character of a byte is registered in a queue entry, then in the output register
// reset clears the group phase, leftover bits, queue pointers and output valid
// up to QUEUE_DEPTH byte jobs wait between front and back under output stall
module base64url_padded_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  b64u_pkg::in_item_t  byte_item,
    output logic                char_valid,
    input  logic                char_stall,
    output b64u_pkg::out_item_t char_item
);

    logic           q_full;
    logic           push;
    logic           pop;
    logic           head_valid;
    b64u_pkg::job_t push_job;
    b64u_pkg::job_t head_job;

    b64u_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    b64u_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64u_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

// ----- hw/rtl/b64u_front.sv -----
// front part: accepts message bytes, tracks the group phase and leftover bits,
// and turns each byte into a job of one to four characters; uses b64u_pkg
module b64u_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  b64u_pkg::in_item_t byte_item,
    input  logic               q_full,
    output logic               push,
    output b64u_pkg::job_t     job
);

    b64u_pkg::phase_t phase_reg;
    b64u_pkg::phase_t phase_next;
    logic [3:0]       carry_reg;
    logic [3:0]       carry_next;
    logic [7:0]       b;
    logic             fin;

    assign b          = byte_item.byte_value;
    assign fin        = byte_item.final_byte;
    assign byte_stall = q_full;
    assign push       = byte_valid && !q_full;

    always_comb
    begin
        phase_next = b64u_pkg::PHASE_0;
        carry_next = 4'd0;
        case (phase_reg)
            b64u_pkg::PHASE_1:
            begin
                if (!fin)
                begin
                    phase_next = b64u_pkg::PHASE_2;
                    carry_next = b[3:0];
                end
            end
            b64u_pkg::PHASE_2:
            begin
                phase_next = b64u_pkg::PHASE_0;
                carry_next = 4'd0;
            end
            default:
            begin
                if (!fin)
                begin
                    phase_next = b64u_pkg::PHASE_1;
                    carry_next = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_comb
    begin
        job.chars    = {b64u_pkg::JOB_SLOTS{b64u_pkg::PAD_CHAR}};
        job.last_idx = 2'd0;
        job.fin      = fin;
        case (phase_reg)
            b64u_pkg::PHASE_1:
            begin
                // only the low two carry bits belong to this group
                job.chars[0] = b64u_pkg::sym({carry_reg[1:0], b[7:4]});
                if (fin)
                begin
                    job.chars[1] = b64u_pkg::sym({b[3:0], 2'b00});
                    job.last_idx = 2'd2;
                end
            end
            b64u_pkg::PHASE_2:
            begin
                job.chars[0] = b64u_pkg::sym({carry_reg, b[7:6]});
                job.chars[1] = b64u_pkg::sym(b[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                job.chars[0] = b64u_pkg::sym(b[7:2]);
                if (fin)
                begin
                    job.chars[1] = b64u_pkg::sym({b[1:0], 4'b0000});
                    job.last_idx = 2'd3;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64u_pkg::PHASE_0;
            carry_reg <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    a_final_restarts_group: assert property (@(posedge clk) disable iff (!rst_n)
        (push && fin) |=> (phase_reg == b64u_pkg::PHASE_0 && carry_reg == 4'd0))
        else $error("group state not cleared after final byte");

    a_phase1_carry_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == b64u_pkg::PHASE_1) |-> (carry_reg[3:2] == 2'b00))
        else $error("phase 1 holds more than two carry bits");

endmodule

// ----- hw/rtl/b64u_queue.sv -----
// short job queue between front and back so that each side stalls on its own
// register based, depth set by the DEPTH parameter; uses b64u_pkg
module b64u_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64u_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output b64u_pkg::job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64u_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job written into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job taken from an empty queue");

endmodule

// ----- hw/rtl/b64u_back.sv -----
// back part: walks the characters of the head job, one per cycle when the output is not
// stalled, into the output register; uses b64u_pkg
module b64u_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64u_pkg::job_t      head_job,
    output logic                pop,
    output logic                char_valid,
    input  logic                char_stall,
    output b64u_pkg::out_item_t char_item
);

    logic                out_valid_reg;
    logic                out_valid_next;
    b64u_pkg::out_item_t out_item_reg;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic                load;
    logic                at_last;

    assign load    = head_valid && (!out_valid_reg || !char_stall);
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = load && at_last;

    assign char_valid = out_valid_reg;
    assign char_item  = out_item_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
            idx_next = at_last ? 2'd0 : idx_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!char_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg.char_code  <= head_job.chars[idx_reg];
            out_item_reg.final_char <= head_job.fin && at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // a job that is partly sent stays at the queue head
    a_partial_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> head_valid)
        else $error("partly sent job left the queue");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= head_job.last_idx))
        else $error("character index past end of job");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for base64url_padded_encoder: byte messages in, url chars out
// holds a char scoreboard class with its own encoder model; depends on b64u_pkg and the rtl
module tb_top;

    localparam int MAX_IDLE       = 13;
    localparam int LONG_HOLD      = 200;
    localparam int BURST_BYTES    = 12;
    localparam int RANDOM_BYTES   = 360;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    class b64_char_board;
        string               alphabet;
        b64u_pkg::phase_t    phase;
        logic [3:0]          carry;
        b64u_pkg::out_item_t pending_chars[$];
        int                  errors;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
            phase    = b64u_pkg::PHASE_0;
            carry    = 4'd0;
            errors   = 0;
        endfunction

        function logic [7:0] url_char(logic [5:0] six);
            return alphabet[int'(six)];
        endfunction

        function void push_char(logic [7:0] code, logic last);
            b64u_pkg::out_item_t c;
            c.char_code  = code;
            c.final_char = last;
            pending_chars.push_back(c);
        endfunction

        // model of the encoder state for one accepted byte
        function void note_byte(b64u_pkg::in_item_t it);
            logic [7:0] b;
            b = it.byte_value;
            case (phase)
                b64u_pkg::PHASE_1:
                begin
                    push_char(url_char({carry[1:0], b[7:4]}), 1'b0);
                    if (it.final_byte)
                    begin
                        push_char(url_char({b[3:0], 2'b00}), 1'b0);
                        push_char(b64u_pkg::PAD_CHAR, 1'b1);
                        phase = b64u_pkg::PHASE_0;
                        carry = 4'd0;
                    end
                    else
                    begin
                        carry = b[3:0];
                        phase = b64u_pkg::PHASE_2;
                    end
                end
                b64u_pkg::PHASE_2:
                begin
                    push_char(url_char({carry, b[7:6]}), 1'b0);
                    push_char(url_char(b[5:0]), it.final_byte);
                    phase = b64u_pkg::PHASE_0;
                    carry = 4'd0;
                end
                default:
                begin
                    push_char(url_char(b[7:2]), 1'b0);
                    if (it.final_byte)
                    begin
                        push_char(url_char({b[1:0], 4'b0000}), 1'b0);
                        push_char(b64u_pkg::PAD_CHAR, 1'b0);
                        push_char(b64u_pkg::PAD_CHAR, 1'b1);
                        phase = b64u_pkg::PHASE_0;
                        carry = 4'd0;
                    end
                    else
                    begin
                        carry = {2'b00, b[1:0]};
                        phase = b64u_pkg::PHASE_1;
                    end
                end
            endcase
        endfunction

        function void check_char(b64u_pkg::out_item_t got);
            b64u_pkg::out_item_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t unexpected char: expected none, actual code %h final %b",
                         $time, got.char_code, got.final_char);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.char_code !== want.char_code)
            begin
                $display("%0t char_code mismatch: expected %h, actual %h",
                         $time, want.char_code, got.char_code);
                errors++;
            end
            if (got.final_char !== want.final_char)
            begin
                $display("%0t final_char mismatch: expected %b, actual %b",
                         $time, want.final_char, got.final_char);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_stall;
    b64u_pkg::in_item_t  byte_item  = '0;
    logic                char_valid;
    logic                char_stall = 1'b0;
    b64u_pkg::out_item_t char_item;

    b64_char_board board = new();

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int bytes_sent   = 0;

    base64url_padded_encoder u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                board.note_byte(byte_item);
            if (char_valid && !char_stall)
                board.check_char(char_item);
            if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // char receiver: random stall per char, or one long hold on request
    initial
    begin : char_sink
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                gap = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if (no_idle)
                gap = 0;
            else
                gap = $urandom_range(MAX_IDLE);
            if (gap > 0)
            begin
                char_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                char_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!char_valid);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        b64u_pkg::in_item_t it;
        it.byte_value = value;
        it.final_byte = last;
        gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(MAX_IDLE);
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (board.outstanding() != 0);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin : byte_source
        int  len;
        bit  held;
        bit  paused;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each group position as last byte, extreme bytes, '-' and '_'
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);

        held   = 1'b0;
        paused = 1'b0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            no_idle = ($urandom_range(4) == 0);
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 9);
            if (!held && bytes_sent > 100)
            begin
                // receiver holds off while bytes keep coming back to back
                held = 1'b1;
                hold_request = 1'b1;
                burst_left = BURST_BYTES;
            end
            for (int i = 0; i < len; i++)
                send_byte(pick_byte(), i == len - 1);
            if (!paused && bytes_sent > 220)
            begin
                paused = 1'b1;
                byte_valid <= 1'b0;
                wait_drained();
            end
        end
        no_idle = 1'b0;
        byte_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
        begin
            $display("%0t %0d expected chars never arrived", $time, board.outstanding());
            board.errors++;
        end
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
